FILE: rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands used by the checker module.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset
`define FCLL_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Signal holds its value in the cycle after the condition
`define FCLL_ASSERT_STABLE(lbl, clk, rstn, cond, sig, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> $stable(sig)) \
    else $error(msg);

`endif

FILE: rtl/fcll_pkg.sv
// ---------------------------------------------------------------------------
// fcll_pkg
// Types, constants and helpers shared by the linked list blocks.
// ---------------------------------------------------------------------------
package fcll_pkg;

  // Pool geometry
  localparam int CAPACITY    = 16;
  localparam int VALUE_WIDTH = 32;
  localparam int SLOT_W      = $clog2(CAPACITY + 1);
  localparam int IDX_W       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FILL_W      = 5;
  localparam int DATA_W      = 32;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [SLOT_W-1:0]      slot_t;
  typedef logic [VALUE_WIDTH-1:0] value_t;

  localparam slot_t                NULL_SLOT = SLOT_W'(CAPACITY);
  localparam logic [FILL_W-1:0]    FILL_FULL = FILL_W'(CAPACITY);

  // Input command codes
  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_FIND   = 2'd1,
    OP_ERASE  = 2'd2,
    OP_WALK   = 2'd3
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_MISS = 2'd1,
    ST_FULL = 2'd2
  } status_e;

  typedef struct packed {
    logic [1:0]               cmd;
    logic signed [DATA_W-1:0] item_value;
  } in_item_t;

  typedef struct packed {
    status_e                  status;
    logic signed [DATA_W-1:0] out_value;
    logic                     out_valid;
    logic [FILL_W-1:0]        fill_count;
    logic                     last;
  } out_item_t;

  // Classified command as it travels through the queue
  typedef struct packed {
    op_e    op;
    value_t value;
  } cmd_t;

  // Sign-extend the input word, then keep the stored width
  function automatic value_t value_from_in(logic signed [DATA_W-1:0] x);
    logic [63:0] w;
    w = 64'(x);
    return w[VALUE_WIDTH-1:0];
  endfunction

  // Zero-extend a stored value onto the result word
  function automatic logic signed [DATA_W-1:0] value_to_out(value_t v);
    logic [63:0] w;
    w = 64'(v);
    return w[DATA_W-1:0];
  endfunction

  // Entry count onto the result field
  function automatic logic [FILL_W-1:0] fill_of(slot_t c);
    logic [63:0] w;
    w = 64'(c);
    return w[FILL_W-1:0];
  endfunction

endpackage

FILE: rtl/fcll_front.sv
// ---------------------------------------------------------------------------
// fcll_front
// Input stage: takes items, decodes the command and pushes to the queue.
// ---------------------------------------------------------------------------
module fcll_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  fcll_pkg::in_item_t in_item_i,
  output logic               push_o,
  output fcll_pkg::cmd_t     push_item_o,
  input  logic               full_i
);

  logic           hold_valid_q, hold_valid_d;
  fcll_pkg::cmd_t hold_q;
  fcll_pkg::cmd_t cls;
  logic           accept;

  // Decode the raw command
  always_comb begin
    cls.value = fcll_pkg::value_from_in(in_item_i.item_value);
    case (in_item_i.cmd)
      fcll_pkg::OP_INSERT: cls.op = fcll_pkg::OP_INSERT;
      fcll_pkg::OP_FIND:   cls.op = fcll_pkg::OP_FIND;
      fcll_pkg::OP_ERASE:  cls.op = fcll_pkg::OP_ERASE;
      default:             cls.op = fcll_pkg::OP_WALK;
    endcase
  end

  // Hold register drains into the queue
  assign push_o      = hold_valid_q && !full_i;
  assign push_item_o = hold_q;
  assign in_stall_o  = hold_valid_q && full_i;
  assign accept      = in_valid_i && !in_stall_o;

  always_comb begin
    hold_valid_d = hold_valid_q;
    if (accept) begin
      hold_valid_d = 1'b1;
    end else if (push_o) begin
      hold_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_valid_q <= 1'b0;
    end else begin
      hold_valid_q <= hold_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      hold_q <= cls;
    end
  end

endmodule

FILE: rtl/fcll_queue.sv
// ---------------------------------------------------------------------------
// fcll_queue
// Short FIFO of decoded commands between the front and back.
// ---------------------------------------------------------------------------
module fcll_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  fcll_pkg::cmd_t push_item_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output fcll_pkg::cmd_t item_o
);

  fcll_pkg::cmd_t                    entry_q [fcll_pkg::QUEUE_DEPTH];
  logic [fcll_pkg::QPTR_W-1:0]       wr_ptr_q, rd_ptr_q;
  logic [fcll_pkg::QCNT_W-1:0]       count_q, count_d;

  assign full_o  = (count_q == fcll_pkg::QCNT_W'(fcll_pkg::QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = entry_q[rd_ptr_q];

  // Occupancy
  always_comb begin
    count_d = count_q;
    case ({push_i, pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == fcll_pkg::QPTR_W'(fcll_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == fcll_pkg::QPTR_W'(fcll_pkg::QUEUE_DEPTH - 1)) ?
                    '0 : rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  // Storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

FILE: rtl/fcll_back.sv
// ---------------------------------------------------------------------------
// fcll_back
// Execution engine: slot pool, list links, free list and result register.
// ---------------------------------------------------------------------------
module fcll_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  fcll_pkg::cmd_t      q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcll_pkg::out_item_t out_item_o
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_TRAV = 2'b10
  } state_e;

  state_e state_q, state_d;

  // Pool storage
  fcll_pkg::value_t slot_value_q [fcll_pkg::CAPACITY];
  fcll_pkg::slot_t  slot_next_q  [fcll_pkg::CAPACITY];
  fcll_pkg::slot_t  slot_free_q  [fcll_pkg::CAPACITY];

  fcll_pkg::slot_t  head_q, tail_q, free_head_q, count_q, count_d;

  // Traversal context
  fcll_pkg::op_e    op_q, op_d;
  fcll_pkg::value_t key_q, key_d;
  fcll_pkg::slot_t  cur_q, cur_d, prev_q, prev_d, step_q, step_d;

  logic                  out_valid_q;
  fcll_pkg::out_item_t   out_item_q, out_item_d, res;
  logic                  load, out_free, ins_do, ers_do, full, hit, fin;

  logic [fcll_pkg::IDX_W-1:0] cur_idx, prev_idx, free_idx, tail_idx;
  fcll_pkg::value_t           cur_val;
  fcll_pkg::slot_t            cur_nxt;

  assign cur_idx  = cur_q[fcll_pkg::IDX_W-1:0];
  assign prev_idx = prev_q[fcll_pkg::IDX_W-1:0];
  assign free_idx = free_head_q[fcll_pkg::IDX_W-1:0];
  assign tail_idx = tail_q[fcll_pkg::IDX_W-1:0];
  assign cur_val  = slot_value_q[cur_idx];
  assign cur_nxt  = slot_next_q[cur_idx];

  assign out_free = !out_valid_q || !out_stall_i;
  assign full     = (count_q >= fcll_pkg::NULL_SLOT) || (free_head_q >= fcll_pkg::NULL_SLOT);
  assign hit      = (cur_val == key_q);
  // traversal ends at a null link or after a full pool of steps
  assign fin      = (cur_nxt >= fcll_pkg::NULL_SLOT) ||
                    (step_q == fcll_pkg::SLOT_W'(fcll_pkg::CAPACITY - 1));

  // Sequencer
  always_comb begin
    state_d = state_q;
    op_d    = op_q;
    key_d   = key_q;
    cur_d   = cur_q;
    prev_d  = prev_q;
    step_d  = step_q;
    q_pop_o = 1'b0;
    load    = 1'b0;
    ins_do  = 1'b0;
    ers_do  = 1'b0;
    res.status     = fcll_pkg::ST_OK;
    res.out_value  = '0;
    res.out_valid  = 1'b0;
    res.fill_count = '0;
    res.last       = 1'b1;
    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          if (q_item_i.op == fcll_pkg::OP_INSERT) begin
            load = 1'b1;
            if (full) begin
              res.status = fcll_pkg::ST_FULL;
            end else begin
              ins_do = 1'b1;
            end
          end else if (head_q >= fcll_pkg::NULL_SLOT) begin
            // empty list: find, erase and walk all miss
            load       = 1'b1;
            res.status = fcll_pkg::ST_MISS;
          end else begin
            state_d = S_TRAV;
            op_d    = q_item_i.op;
            key_d   = q_item_i.value;
            cur_d   = head_q;
            prev_d  = fcll_pkg::NULL_SLOT;
            step_d  = '0;
          end
        end
      end
      S_TRAV: begin
        if (out_free) begin
          if (op_q == fcll_pkg::OP_WALK) begin
            load          = 1'b1;
            res.out_value = fcll_pkg::value_to_out(cur_val);
            res.out_valid = 1'b1;
            res.last      = fin;
          end else if (hit) begin
            load   = 1'b1;
            ers_do = (op_q == fcll_pkg::OP_ERASE);
          end else if (fin) begin
            load       = 1'b1;
            res.status = fcll_pkg::ST_MISS;
          end
          if ((op_q != fcll_pkg::OP_WALK && hit) || fin) begin
            state_d = S_IDLE;
          end else begin
            cur_d  = cur_nxt;
            prev_d = cur_q;
            step_d = step_q + 1'b1;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Entry count after this command
  always_comb begin
    count_d = count_q;
    if (ins_do) begin
      count_d = count_q + 1'b1;
    end else if (ers_do && count_q != '0) begin
      count_d = count_q - 1'b1;
    end
  end

  // Result with the entry count after this command
  always_comb begin
    out_item_d            = res;
    out_item_d.fill_count = fcll_pkg::fill_of(count_d);
  end

  always_comb begin
    out_item_o = out_item_q;
  end
  assign out_valid_o = out_valid_q;

  // Control state, links and free list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= fcll_pkg::NULL_SLOT;
      tail_q      <= fcll_pkg::NULL_SLOT;
      free_head_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < fcll_pkg::CAPACITY; i++) begin
        slot_next_q[i] <= fcll_pkg::NULL_SLOT;
        slot_free_q[i] <= fcll_pkg::SLOT_W'(i + 1);
      end
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      // append at the tail
      if (ins_do) begin
        free_head_q           <= slot_free_q[free_idx];
        slot_free_q[free_idx] <= fcll_pkg::NULL_SLOT;
        slot_next_q[free_idx] <= fcll_pkg::NULL_SLOT;
        if (tail_q < fcll_pkg::NULL_SLOT) begin
          slot_next_q[tail_idx] <= free_head_q;
        end
        if (head_q >= fcll_pkg::NULL_SLOT) begin
          head_q <= free_head_q;
        end
        tail_q <= free_head_q;
      end
      // unlink the matching node and push its slot
      if (ers_do) begin
        if (head_q == cur_q) begin
          head_q <= cur_nxt;
        end
        if (tail_q == cur_q) begin
          tail_q <= prev_q;
        end
        if (prev_q < fcll_pkg::NULL_SLOT) begin
          slot_next_q[prev_idx] <= cur_nxt;
        end
        slot_next_q[cur_idx] <= fcll_pkg::NULL_SLOT;
        slot_free_q[cur_idx] <= free_head_q;
        free_head_q          <= cur_q;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    key_q  <= key_d;
    cur_q  <= cur_d;
    prev_q <= prev_d;
    step_q <= step_d;
    if (ins_do) begin
      slot_value_q[free_idx] <= q_item_i.value;
    end
    if (load) begin
      out_item_q <= out_item_d;
    end
  end

endmodule

FILE: rtl/fixed_capacity_linked_list.sv
// ---------------------------------------------------------------------------
// fixed_capacity_linked_list
// Singly linked list of signed values in a fixed slot pool with a free list.
// ---------------------------------------------------------------------------
// Commands enter through a one-item input register and a two-entry queue, so
// new items are taken while the engine is busy. The engine runs one command at
// a time. Insert and any command on an empty list complete from the idle state.
// Find and erase follow one link per cycle after a setup step, up to CAPACITY
// (16) links. Walk emits one element per cycle. The link-following loop runs
// through the slot arrays; a stalled result register pauses the engine.
// Insert into a full pool returns status full and changes nothing.
module fixed_capacity_linked_list (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fcll_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fcll_pkg::out_item_t out_item_o
);

  logic           push, full, q_valid, q_pop;
  fcll_pkg::cmd_t push_item, q_item;

  fcll_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .push_o      (push),
    .push_item_o (push_item),
    .full_i      (full)
  );

  fcll_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (full),
    .pop_i       (q_pop),
    .valid_o     (q_valid),
    .item_o      (q_item)
  );

  fcll_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

FILE: rtl/fcll_checker.sv
// ---------------------------------------------------------------------------
// fcll_checker
// Port-level checks on the linked list block, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module fcll_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input fcll_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input fcll_pkg::out_item_t out_item_o
);

  // Input channel holds under stall
  `FCLL_ASSERT_STABLE(a_in_stable, clk_i, rst_ni, in_valid_i && in_stall_o, in_item_i, "input item changed while stalled")

  // Result channel holds under stall
  `FCLL_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i |=> out_valid_o, "result dropped while stalled")
  `FCLL_ASSERT_STABLE(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, out_item_o, "result changed while stalled")

  // Only walk elements may be non-final, and they always carry a value
  `FCLL_ASSERT(a_partial_walk, clk_i, rst_ni, out_valid_o && !out_item_o.last |-> out_item_o.out_valid && out_item_o.status == fcll_pkg::ST_OK, "non-final result is not a walk element")

  // A rejected insert only happens with the pool full
  `FCLL_ASSERT(a_full_count, clk_i, rst_ni, out_valid_o && out_item_o.status == fcll_pkg::ST_FULL |-> out_item_o.fill_count == fcll_pkg::FILL_FULL, "insert rejected below capacity")

endmodule

bind fixed_capacity_linked_list fcll_checker u_fcll_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);
